// ----- rtl/psbs_pkg.sv -----
// psbs_pkg: shared constants and types for the point-set bounding sphere core.
// No dependencies.
`timescale 1ns / 1ps
package psbs_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = AddrW + 1;
  localparam int CoordW    = 24;
  localparam int PointW    = 3 * CoordW;
  localparam int DiffW     = CoordW + 1;
  localparam int SqW       = 2 * DiffW;
  localparam int D2W       = SqW + 2;
  localparam int RootW     = D2W / 2;
  localparam logic [16:0] ScaleK = 17'd65601;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_CTR   = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_AXIS  = 8'b0000_1000,
    ST_SQRT  = 8'b0001_0000,
    ST_SCALE = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_WAIT  = 8'b1000_0000
  } state_t;
endpackage

// ----- rtl/psbs_if.sv -----
// psbs_if: valid/ready channel interfaces for input points and results.
// Depends on psbs_pkg.
`timescale 1ns / 1ps
interface psbs_in_if;
  import psbs_pkg::*;
  logic   valid;
  logic   ready;
  coord_t px;
  coord_t py;
  coord_t pz;
  logic   last_point;
  modport source (output valid, px, py, pz, last_point, input ready);
  modport sink   (input valid, px, py, pz, last_point, output ready);
endinterface

interface psbs_out_if;
  import psbs_pkg::*;
  logic        valid;
  logic        ready;
  coord_t      center_x;
  coord_t      center_y;
  coord_t      center_z;
  logic [23:0] radius;
  logic        overflowed;
  modport source (output valid, center_x, center_y, center_z, radius, overflowed,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, radius, overflowed,
                  output ready);
endinterface

// ----- rtl/psbs_ram.sv -----
// psbs_ram: generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module psbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/point_set_bounding_sphere_core.sv -----
// point_set_bounding_sphere_core: top level; stores points, tracks the box,
// then scans the store with one shared subtract/square unit and a bitwise sqrt.
// Depends on psbs_pkg, psbs_if, psbs_ram.
//
//   channel | dir | payload                                  | handshake
//   in_     | in  | px, py, pz, last_point                   | valid/ready
//   out_    | out | center_x..z, radius, overflowed          | valid/ready
//
// Points load at one per cycle. After the last point: a center step, for each
// stored point a read and then one axis per cycle, RootW sqrt iterations, a
// scale step and a step that clears the set; then the result waits in the
// output register. The scan runs sequentially through the single RAM read
// port.
// Reset (synchronous, active low) empties the set; no clearing pass is needed.
`timescale 1ns / 1ps
module point_set_bounding_sphere_core (
  input logic       clk,
  input logic       rst_n,
  psbs_in_if.sink   in_ch,
  psbs_out_if.source out_ch
);
  import psbs_pkg::*;

  state_t state_r, state_nxt;
  logic [CntW-1:0]  count_r;
  logic [AddrW-1:0] idx_r;
  logic [1:0]       axis_r;
  logic             drop_r;
  coord_t min_r [3];
  coord_t max_r [3];
  coord_t ctr_r [3];
  logic [D2W-1:0]   acc_r, best_r;
  logic [D2W-1:0]   rem_r;
  logic [RootW-1:0] root_r;
  logic [$clog2(RootW)-1:0] it_r;
  logic [PointW-1:0] rdata;
  logic [23:0]      radius_r;
  logic             ovf_r;

  logic take;
  logic store_ok;
  assign in_ch.ready = (state_r == ST_LOAD);
  assign take        = in_ch.valid && in_ch.ready;
  assign store_ok    = (count_r != CntW'(MaxPoints));

  psbs_ram #(.Width(PointW), .Depth(MaxPoints)) u_store (
    .clk  (clk),
    .we   (take && store_ok),
    .waddr(count_r[AddrW-1:0]),
    .wdata({in_ch.pz, in_ch.py, in_ch.px}),
    .raddr(idx_r),
    .rdata(rdata)
  );

  // Shared unit: one axis difference squared per cycle in ST_AXIS.
  coord_t           cur;
  logic signed [DiffW-1:0] dif;
  logic [DiffW-1:0] mag;
  logic [SqW-1:0]   sq;
  logic [D2W-1:0]   acc_nxt;
  always_comb begin
    case (axis_r)
      2'd0:    cur = rdata[CoordW-1:0];
      2'd1:    cur = rdata[2*CoordW-1:CoordW];
      default: cur = rdata[3*CoordW-1:2*CoordW];
    endcase
    dif     = DiffW'(cur) - DiffW'(ctr_r[axis_r]);
    mag     = dif[DiffW-1] ? DiffW'(-dif) : DiffW'(dif);
    sq      = mag * mag;
    acc_nxt = acc_r + D2W'(sq);
  end

  // Sqrt step: two bits of the radicand per iteration, restoring.
  logic [RootW+1:0] part;
  logic [RootW+1:0] top;
  logic [RootW+1:0] tnext;
  logic             fits;
  always_comb begin
    part  = {root_r, 2'b01};
    top   = {rem_r[RootW-1:0], acc_r[D2W-1 -: 2]};
    fits  = (top >= part);
    tnext = fits ? top - part : top;
  end

  logic [RootW+17:0] scaled;
  assign scaled = root_r * ScaleK;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (take && in_ch.last_point) state_nxt = ST_CTR;
      ST_CTR:   state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_AXIS;
      ST_AXIS:  if (axis_r == 2'd2)
                  state_nxt = (32'(idx_r) + 1 == 32'(count_r)) ? ST_SQRT : ST_RD;
      ST_SQRT:  if (it_r == $bits(it_r)'(RootW - 1)) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_WAIT;
      ST_WAIT:  if (out_ch.ready) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_r[a] <= '0;
        max_r[a] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (take) begin
            if (store_ok) begin
              count_r <= count_r + 1'b1;
              if (count_r == '0 || in_ch.px < min_r[0]) min_r[0] <= in_ch.px;
              if (count_r == '0 || in_ch.px > max_r[0]) max_r[0] <= in_ch.px;
              if (count_r == '0 || in_ch.py < min_r[1]) min_r[1] <= in_ch.py;
              if (count_r == '0 || in_ch.py > max_r[1]) max_r[1] <= in_ch.py;
              if (count_r == '0 || in_ch.pz < min_r[2]) min_r[2] <= in_ch.pz;
              if (count_r == '0 || in_ch.pz > max_r[2]) max_r[2] <= in_ch.pz;
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          count_r <= '0;
          drop_r  <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            min_r[a] <= '0;
            max_r[a] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  logic [CoordW:0] csum [3];
  always_comb begin
    for (int a = 0; a < 3; a++)
      csum[a] = {min_r[a][CoordW-1], min_r[a]} + {max_r[a][CoordW-1], max_r[a]};
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_CTR: begin
        for (int a = 0; a < 3; a++) ctr_r[a] <= csum[a][CoordW:1];
        idx_r  <= '0;
        axis_r <= 2'd0;
        best_r <= '0;
        ovf_r  <= drop_r;
      end
      ST_RD: begin
        axis_r <= 2'd0;
        acc_r  <= '0;
      end
      ST_AXIS: begin
        acc_r <= acc_nxt;
        if (axis_r == 2'd2) begin
          axis_r <= 2'd0;
          idx_r  <= idx_r + 1'b1;
          if (acc_nxt > best_r) best_r <= acc_nxt;
          if (state_nxt == ST_SQRT) begin
            acc_r  <= (acc_nxt > best_r) ? acc_nxt : best_r;
            rem_r  <= '0;
            root_r <= '0;
            it_r   <= '0;
          end
        end else begin
          axis_r <= axis_r + 1'b1;
        end
      end
      ST_SQRT: begin
        acc_r  <= {acc_r[D2W-3:0], 2'b00};
        rem_r  <= D2W'(tnext);
        root_r <= {root_r[RootW-2:0], fits};
        it_r   <= it_r + 1'b1;
      end
      ST_SCALE: begin
        radius_r <= (scaled[RootW+17:16] > (RootW+2)'(24'hFFFFFF)) ? 24'hFFFFFF
                                                                  : scaled[39:16];
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = (state_r == ST_WAIT);
  assign out_ch.center_x   = ctr_r[0];
  assign out_ch.center_y   = ctr_r[1];
  assign out_ch.center_z   = ctr_r[2];
  assign out_ch.radius     = radius_r;
  assign out_ch.overflowed = ovf_r;
endmodule

// ----- rtl/psbs_checker.sv -----
// psbs_checker: port-level checks for point_set_bounding_sphere_core.
// No package or interface dependencies; bound to the top level below.
`timescale 1ns / 1ps
module psbs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open while result pending");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after last point");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready) else $error("no return to load");
endmodule

bind point_set_bounding_sphere_core psbs_checker u_psbs_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_point),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
